// ===== rtl/core/erm_pkg.sv =====
package erm_pkg;

  localparam int unsigned WINDOW_SIZE = 13;
  localparam int unsigned IDX_W       = $clog2(WINDOW_SIZE);
  localparam int unsigned MEDIAN_IDX  = WINDOW_SIZE / 2;

  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned CAL_W   = 8;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned TDATA_OUT_W = 16;

  localparam logic [CAL_W-1:0] CALIB_RESET = 8'd5;

  // mm = floor(d * 50 / 291). A truncated reciprocal 11260 / 2^16 gives an
  // estimate that is low by at most one; the remainder check fixes that.
  localparam int unsigned RECIP_W  = 14;
  localparam int unsigned MM_SHIFT = 16;
  localparam logic [RECIP_W-1:0] MM_RECIP = 14'd11260;
  localparam int unsigned PROD_W = WIDTH_W + RECIP_W;
  localparam int unsigned REM_W  = 23;
  localparam logic [REM_W-1:0] MM_NUM = 23'd50;
  localparam logic [REM_W-1:0] MM_DEN = 23'd291;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORR,
    ST_INSERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic corr;
  } conv_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
    logic clear;
  } win_ctl_t;

  typedef struct packed {
    logic placed;
    logic full;
  } win_stat_t;

endpackage

// ===== rtl/core/echo_range_median_filter.sv =====
// Median filter for ultrasonic echo widths. Each transaction on the input
// stream carries one echo pulse width in microseconds. The block subtracts
// the calibration offset (saturating at zero), converts the difference d to
// millimetres as floor(d*50/291), and inserts the distance into a 13-entry
// window kept in descending order, a new value landing after any equal
// ones. Every 13th sample completes the window: its middle entry leaves as
// one output transaction and the window starts over empty. Each sample is
// converted in order (offset subtracted and loaded, multiplied by the
// reciprocal, corrected), then walked through the window from its first free
// slot, moving smaller entries up; the walk uses a single comparator that
// visits one entry a cycle. The sample that completes a window then passes
// through an emit state that hands the median to the output register, and
// waits there while an earlier median has not been taken. The input is not
// ready while a sample is being processed. The offset register resets to 5
// and should only be written while the block is idle.
module echo_range_median_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [erm_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [15:0] echo_width_us
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [erm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // [13:0] median_mm, [15:14] zero
  input  logic                               cfg_we,
  input  logic [erm_pkg::CAL_W-1:0]          cfg_wdata
);

  erm_pkg::state_t           state;
  erm_pkg::state_t           state_next;
  erm_pkg::conv_ctl_t        conv_ctl;
  erm_pkg::win_ctl_t         win_ctl;
  erm_pkg::win_stat_t        win_stat;
  logic [erm_pkg::CAL_W-1:0] calib_offset_us;
  logic [erm_pkg::DIST_W-1:0] dist_mm;
  logic [erm_pkg::DIST_W-1:0] median;
  logic                      emit_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_offset_us <= erm_pkg::CALIB_RESET;
    end else if (cfg_we) begin
      calib_offset_us <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      erm_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = erm_pkg::ST_MUL;
        end
      end
      erm_pkg::ST_MUL: begin
        state_next = erm_pkg::ST_CORR;
      end
      erm_pkg::ST_CORR: begin
        state_next = erm_pkg::ST_INSERT;
      end
      erm_pkg::ST_INSERT: begin
        if (win_stat.full) begin
          state_next = erm_pkg::ST_EMIT;
        end else if (win_stat.placed) begin
          state_next = erm_pkg::ST_IDLE;
        end
      end
      erm_pkg::ST_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = erm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = erm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    emit_fire     = 1'b0;
    conv_ctl      = '0;
    win_ctl       = '0;
    case (state)
      erm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        conv_ctl.load = s_axis_tvalid;
      end
      erm_pkg::ST_MUL: begin
        conv_ctl.mul = 1'b1;
      end
      erm_pkg::ST_CORR: begin
        conv_ctl.corr = 1'b1;
        win_ctl.start = 1'b1;
      end
      erm_pkg::ST_INSERT: begin
        win_ctl.step = 1'b1;
      end
      erm_pkg::ST_EMIT: begin
        emit_fire     = !m_axis_tvalid || m_axis_tready;
        win_ctl.clear = emit_fire;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  erm_conv u_conv (
    .clk     (clk),
    .ctl     (conv_ctl),
    .width   (s_axis_tdata[erm_pkg::WIDTH_W-1:0]),
    .offset  (calib_offset_us),
    .dist_mm (dist_mm)
  );

  erm_window u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (win_ctl),
    .dist_mm (dist_mm),
    .stat    (win_stat),
    .median  (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_axis_tdata <= erm_pkg::TDATA_OUT_W'(median);
    end
  end

endmodule

// ===== rtl/core/erm_conv.sv =====
module erm_conv (
  input  logic                          clk,
  input  erm_pkg::conv_ctl_t            ctl,
  input  logic [erm_pkg::WIDTH_W-1:0]   width,
  input  logic [erm_pkg::CAL_W-1:0]     offset,
  output logic [erm_pkg::DIST_W-1:0]    dist_mm
);

  logic [erm_pkg::WIDTH_W-1:0] d;
  logic [erm_pkg::WIDTH_W-1:0] d_next;
  logic [erm_pkg::PROD_W-1:0]  prod;
  logic [erm_pkg::DIST_W-1:0]  q0;
  logic [erm_pkg::REM_W-1:0]   scaled;
  logic [erm_pkg::REM_W-1:0]   back;
  logic [erm_pkg::REM_W-1:0]   rem;
  logic [erm_pkg::DIST_W-1:0]  dist_next;

  always_comb begin
    if (width > erm_pkg::WIDTH_W'(offset)) begin
      d_next = width - erm_pkg::WIDTH_W'(offset);
    end else begin
      d_next = '0;
    end
  end

  // The estimate never exceeds the true quotient, so the remainder is
  // non-negative and below twice the divisor.
  always_comb begin
    q0        = prod[erm_pkg::MM_SHIFT +: erm_pkg::DIST_W];
    scaled    = erm_pkg::REM_W'(d) * erm_pkg::MM_NUM;
    back      = erm_pkg::REM_W'(q0) * erm_pkg::MM_DEN;
    rem       = scaled - back;
    dist_next = (rem >= erm_pkg::MM_DEN) ? q0 + 1'b1 : q0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d <= d_next;
    end
    if (ctl.mul) begin
      prod <= erm_pkg::PROD_W'(d) * erm_pkg::PROD_W'(erm_pkg::MM_RECIP);
    end
    if (ctl.corr) begin
      dist_mm <= dist_next;
    end
  end

endmodule

// ===== rtl/core/erm_window.sv =====
module erm_window (
  input  logic                          clk,
  input  logic                          rst,
  input  erm_pkg::win_ctl_t             ctl,
  input  logic [erm_pkg::DIST_W-1:0]    dist_mm,
  output erm_pkg::win_stat_t            stat,
  output logic [erm_pkg::DIST_W-1:0]    median
);

  logic [erm_pkg::DIST_W-1:0] win [erm_pkg::WINDOW_SIZE];
  logic [erm_pkg::IDX_W-1:0]  count;
  logic [erm_pkg::IDX_W-1:0]  idx;
  logic [erm_pkg::IDX_W-1:0]  idx_m1;
  logic [erm_pkg::DIST_W-1:0] prev;
  logic                       shift_up;

  // The walk starts at the first free slot and moves smaller entries up by
  // one until it meets an entry that is not smaller than the new distance.
  always_comb begin
    idx_m1   = idx - 1'b1;
    prev     = (idx != '0) ? win[idx_m1] : '0;
    shift_up = (idx != '0) && (prev < dist_mm);
    stat.placed = ctl.step && !shift_up;
    stat.full   = stat.placed &&
                  (count == erm_pkg::IDX_W'(erm_pkg::WINDOW_SIZE - 1));
    median      = win[erm_pkg::MEDIAN_IDX];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (stat.placed) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx <= count;
    end else if (ctl.step && shift_up) begin
      idx <= idx_m1;
    end
    if (ctl.step) begin
      win[idx] <= shift_up ? prev : dist_mm;
    end
  end

endmodule

// ===== rtl/core/erm_checker.sv =====
module erm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [erm_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

  // A sample is worked on in later states, so the input closes at once.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted sample");

  // A median can only appear after the input has been closed for a sample.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("median appeared without a sample in flight");

  // Medians stay within the range of the millimetre conversion.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= erm_pkg::TDATA_OUT_W'(11260)))
    else $error("median out of range");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled median changed or dropped");

endmodule

bind echo_range_median_filter erm_checker u_erm_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned SETTLE_WAIT  = 24;
  localparam int unsigned MAX_PRINTED  = 30;
  localparam int unsigned WIDTH_MAX    = 65535;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [erm_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;   // [15:0] echo_width_us
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [erm_pkg::TDATA_OUT_W-1:0] m_axis_tdata;        // [13:0] median_mm, [15:14] zero
  logic                            cfg_we = 1'b0;
  logic [erm_pkg::CAL_W-1:0]       cfg_wdata = '0;

  // Predicted state of the block.
  logic [erm_pkg::CAL_W-1:0]  offset_us = erm_pkg::CALIB_RESET;
  logic [erm_pkg::DIST_W-1:0] window_mm [erm_pkg::WINDOW_SIZE];
  int unsigned                window_fill = 0;
  logic [erm_pkg::DIST_W-1:0] expected_medians [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic [erm_pkg::DIST_W-1:0] median_want;

  echo_range_median_filter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** echo_range_median_filter: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [erm_pkg::DIST_W-1:0] echo_to_mm(
      input logic [erm_pkg::WIDTH_W-1:0] width_us);
    int unsigned diff;
    diff = (width_us > erm_pkg::WIDTH_W'(offset_us)) ?
           32'(width_us) - 32'(offset_us) : 0;
    return erm_pkg::DIST_W'((diff * 50) / 291);
  endfunction

  // Inserts the distance in descending order, after any equal entries, and
  // queues the middle entry once the window is full.
  task automatic insert_distance(input logic [erm_pkg::WIDTH_W-1:0] width_us);
    logic [erm_pkg::DIST_W-1:0] dist_mm;
    int unsigned pos;
    dist_mm = echo_to_mm(width_us);
    pos = window_fill;
    for (int unsigned i = 0; i < window_fill; i++) begin
      if (window_mm[i] < dist_mm) begin
        pos = i;
        break;
      end
    end
    for (int unsigned i = window_fill; i > pos; i--)
      window_mm[i] = window_mm[i-1];
    window_mm[pos] = dist_mm;
    window_fill++;
    if (window_fill == erm_pkg::WINDOW_SIZE) begin
      expected_medians.push_back(window_mm[erm_pkg::MEDIAN_IDX]);
      window_fill = 0;
    end
  endtask

  // The receiver stalls at random, one decision per cycle.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_medians.size() == 0) begin
        report_mismatch("median with none pending",
                        32'(m_axis_tdata[erm_pkg::DIST_W-1:0]), 0);
      end else begin
        median_want = expected_medians.pop_front();
        if (m_axis_tdata[erm_pkg::DIST_W-1:0] != median_want)
          report_mismatch("median_mm", 32'(m_axis_tdata[erm_pkg::DIST_W-1:0]),
                          32'(median_want));
        if (m_axis_tdata[erm_pkg::TDATA_OUT_W-1:erm_pkg::DIST_W] != '0)
          report_mismatch("tdata pad bits",
                          32'(m_axis_tdata[erm_pkg::TDATA_OUT_W-1:erm_pkg::DIST_W]), 0);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the
  // transaction, with tvalid left high so back-to-back items stay gapless.
  task automatic send_echo(input logic [erm_pkg::WIDTH_W-1:0] width_us);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= erm_pkg::WIDTH_W'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= width_us;
    do @(posedge clk); while (!s_axis_tready);
    insert_distance(width_us);
    @(negedge clk);
  endtask

  // Drains every pending median and lets a sample without a result finish.
  task automatic drain_to_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_medians.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_offset(input logic [erm_pkg::CAL_W-1:0] value);
    drain_to_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= erm_pkg::CAL_W'($urandom);
    offset_us = value;
    @(negedge clk);
  endtask

  // Offset at its reset value: widths below and at the offset, both width
  // extremes, alternating bit patterns and several equal distances.
  task automatic test_reset_offset_window();
    logic [erm_pkg::WIDTH_W-1:0] widths [erm_pkg::WINDOW_SIZE] =
        '{0, 4, 5, 6, 16'hFFFF, 16'h5555, 16'hAAAA,
          1000, 1000, 1000, 297, 296, 2000};
    foreach (widths[i]) send_echo(widths[i]);
  endtask

  // Zero offset with a majority of full-scale widths gives the largest median.
  task automatic test_full_scale_median();
    logic [erm_pkg::WIDTH_W-1:0] widths [erm_pkg::WINDOW_SIZE] =
        '{16'hFFFF, 0, 16'hFFFF, 1, 16'hFFFF, 291,
          16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h00FF,
          16'hFFFF, 16'hFF00, 16'hFFFF};
    write_offset(8'd0);
    foreach (widths[i]) send_echo(widths[i]);
  endtask

  task automatic test_random_echoes(input int unsigned count,
                                    input logic [erm_pkg::CAL_W-1:0] offset);
    logic [erm_pkg::WIDTH_W-1:0] width_us;
    logic [erm_pkg::WIDTH_W-1:0] last_width;
    last_width = '0;
    write_offset(offset);
    repeat (count) begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(3))
            0: width_us = '0;
            1: width_us = erm_pkg::WIDTH_W'(WIDTH_MAX);
            2: width_us = erm_pkg::WIDTH_W'(offset);
            default: width_us = erm_pkg::WIDTH_W'(offset) + 1'b1;
          endcase
        end
        1, 2, 3: width_us = erm_pkg::WIDTH_W'($urandom_range(offset + 600));
        4: width_us = last_width;
        default: width_us = erm_pkg::WIDTH_W'($urandom);
      endcase
      send_echo(width_us);
      last_width = width_us;
    end
  endtask

  initial begin
    foreach (window_mm[i]) window_mm[i] = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 81;
    test_reset_offset_window();
    test_full_scale_median();
    test_random_echoes(71, 8'd0);
    test_random_echoes(71, 8'd255);

    send_idle_pct = 81;
    recv_idle_pct = 31;
    test_random_echoes(71, erm_pkg::CAL_W'($urandom));
    test_random_echoes(71, erm_pkg::CALIB_RESET);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_echoes(71, erm_pkg::CAL_W'($urandom));
    test_random_echoes(71, erm_pkg::CAL_W'($urandom_range(255, 200)));

    drain_to_idle();
    if (mismatch_count == 0) begin
      $display("** echo_range_median_filter: PASSED **");
    end else begin
      $display("** echo_range_median_filter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== echo_range_median_filter.f =====
rtl/core/erm_pkg.sv
rtl/core/erm_conv.sv
rtl/core/erm_window.sv
rtl/core/echo_range_median_filter.sv
rtl/core/erm_checker.sv
verif/testbench.sv
